// ===== design/mmlbs_pkg.sv =====
package mmlbs_pkg;

    localparam int MAX_ITEMS   = 4096;
    localparam int WEIGHT_BITS = 32;
    localparam int ADDR_W      = $clog2(MAX_ITEMS);
    localparam int CNT_W       = $clog2(MAX_ITEMS + 1);
    localparam int WEIGHT_W    = 32;
    localparam int LOAD_W      = 44;
    localparam int BOUND_W     = LOAD_W + 1;
    localparam int RANK_W      = 11;
    localparam int PROBE_W     = 7;
    localparam int DIV_CNT_W   = $clog2(LOAD_W);

    localparam logic [WEIGHT_W-1:0] WEIGHT_MASK =
        (WEIGHT_BITS >= WEIGHT_W) ? {WEIGHT_W{1'b1}}
                                  : WEIGHT_W'((64'd1 << WEIGHT_BITS) - 64'd1);

    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic                last;
    } item_t;

    typedef struct packed {
        logic [LOAD_W-1:0]  min_max_load;
        logic [PROBE_W-1:0] probe_count;
    } result_t;

    typedef struct packed {
        logic                en;
        logic [ADDR_W-1:0]   addr;
        logic [WEIGHT_W-1:0] data;
    } scan_wr_t;

    typedef struct packed {
        logic               start;
        logic [BOUND_W-1:0] bound;
        logic [RANK_W-1:0]  ranks;
        logic [CNT_W-1:0]   count;
    } scan_req_t;

    typedef struct packed {
        logic done;
        logic fit;
    } scan_rsp_t;

endpackage

// ===== design/mmlbs_div.sv =====
module mmlbs_div
    import mmlbs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [LOAD_W-1:0] dividend,
    input  logic [RANK_W-1:0] divisor,
    output logic              done,
    output logic [LOAD_W-1:0] quotient
);

    logic                 active_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [RANK_W-1:0]    div_reg;
    logic [RANK_W-1:0]    rem_reg;
    logic [LOAD_W-1:0]    quo_reg;
    logic [RANK_W:0]      rem_shift;
    logic                 take;

    assign rem_shift = {rem_reg, quo_reg[LOAD_W-1]};
    assign take      = rem_shift >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                active_reg <= 1'b1;
                cnt_reg    <= DIV_CNT_W'(LOAD_W - 1);
            end
            else if (active_reg)
            begin
                if (cnt_reg == '0)
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (active_reg)
        begin
            rem_reg <= take ? RANK_W'(rem_shift - {1'b0, div_reg}) : rem_shift[RANK_W-1:0];
            quo_reg <= {quo_reg[LOAD_W-2:0], take};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== design/mmlbs_scan.sv =====
module mmlbs_scan
    import mmlbs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  scan_wr_t  wr,
    input  scan_req_t req,
    output scan_rsp_t rsp
);

    logic [WEIGHT_W-1:0] mem [MAX_ITEMS];

    logic                active_reg;
    logic                dv_reg;
    logic                done_reg;
    logic                fit_reg;
    logic [CNT_W-1:0]    addr_reg;
    logic [WEIGHT_W-1:0] rd_data_reg;
    logic [BOUND_W:0]    load_reg;
    logic [RANK_W-1:0]   used_reg;
    logic [BOUND_W-1:0]  bound_reg;
    logic [RANK_W-1:0]   ranks_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                issue;
    logic [BOUND_W:0]    sum;

    assign issue = active_reg && (addr_reg < count_reg);
    assign sum   = load_reg + (BOUND_W + 1)'(rd_data_reg);

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_data_reg <= mem[addr_reg[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            dv_reg     <= 1'b0;
            done_reg   <= 1'b0;
            fit_reg    <= 1'b0;
            addr_reg   <= '0;
            load_reg   <= '0;
            used_reg   <= '0;
            bound_reg  <= '0;
            ranks_reg  <= '0;
            count_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                active_reg <= 1'b1;
                dv_reg     <= 1'b0;
                addr_reg   <= '0;
                load_reg   <= '0;
                used_reg   <= RANK_W'(1);
                bound_reg  <= req.bound;
                ranks_reg  <= req.ranks;
                count_reg  <= req.count;
            end
            else if (active_reg)
            begin
                dv_reg <= issue;
                if (issue)
                begin
                    addr_reg <= addr_reg + 1'b1;
                end
                if (dv_reg)
                begin
                    if (sum > {1'b0, bound_reg})
                    begin
                        if (used_reg >= ranks_reg)
                        begin
                            active_reg <= 1'b0;
                            done_reg   <= 1'b1;
                            fit_reg    <= 1'b0;
                        end
                        else
                        begin
                            used_reg <= used_reg + 1'b1;
                            load_reg <= (BOUND_W + 1)'(rd_data_reg);
                        end
                    end
                    else
                    begin
                        load_reg <= sum;
                    end
                end
                else if (!issue)
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                    fit_reg    <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.fit  = fit_reg;

endmodule

// ===== design/min_max_load_binary_search_unit.sv =====
// Min-max load search over a sequence of task weights.
// Items: pulse start with an item (weight, last) while busy is low. Items with
// last low are stored at one per cycle and busy stays low. Once MAX_ITEMS are
// held, further weights are dropped, but a dropped item with last high still
// ends the sequence.
// The item with last high raises busy. The block then divides the total by
// rank_count on a one-bit-per-cycle divider and binary-searches the bound:
// each probe walks the stored weights through the memory read port, one
// weight per cycle, and a probe ends early when the greedy split runs out
// of ranks. A search takes at most 33 probes.
// The result appears on result for exactly one cycle with result_valid high,
// in the cycle busy falls; the receiver cannot stall it. The sequence state
// is then cleared for the next sequence.
// Configuration: cfg_data is the rank count, written when cfg_valid is high
// (cfg_ready is always high); write it only while idle. Zero acts as one.
// Reset: rank count becomes 1, the block is idle with no sequence held.
module min_max_load_binary_search_unit
    import mmlbs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  item_t             item,
    output logic              result_valid,
    output result_t           result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [RANK_W-1:0] cfg_data
);

    localparam logic [2:0] ST_LOAD  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_INIT  = 3'd2;
    localparam logic [2:0] ST_CHECK = 3'd3;
    localparam logic [2:0] ST_WAIT  = 3'd4;

    logic [2:0]          state_reg;
    logic [RANK_W-1:0]   rank_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [LOAD_W-1:0]   total_reg;
    logic [WEIGHT_W-1:0] largest_reg;
    logic [BOUND_W-1:0]  lo_reg;
    logic [BOUND_W-1:0]  hi_reg;
    logic [BOUND_W-1:0]  res_reg;
    logic [BOUND_W-1:0]  mid_reg;
    logic [PROBE_W-1:0]  probes_reg;
    logic                out_valid_reg;
    result_t             out_reg;

    logic                accept;
    logic                room;
    logic [WEIGHT_W-1:0] w_masked;
    logic [LOAD_W-1:0]   total_next;
    logic [RANK_W-1:0]   ranks;
    logic                div_done;
    logic [LOAD_W-1:0]   avg;
    logic [BOUND_W-1:0]  avg_ext;
    logic [BOUND_W-1:0]  largest_ext;
    logic [BOUND_W-1:0]  mid_calc;
    scan_wr_t            scan_wr;
    scan_req_t           scan_req;
    scan_rsp_t           scan_rsp;

    assign accept     = start && !busy;
    assign room       = count_reg < CNT_W'(MAX_ITEMS);
    assign w_masked   = item.weight & WEIGHT_MASK;
    assign total_next = room ? total_reg + LOAD_W'(w_masked) : total_reg;
    assign ranks      = (rank_reg == '0) ? RANK_W'(1) : rank_reg;
    assign avg_ext    = BOUND_W'(avg);
    assign largest_ext = BOUND_W'(largest_reg);
    assign mid_calc   = lo_reg + ((hi_reg - lo_reg) >> 1);

    assign scan_wr.en   = accept && room;
    assign scan_wr.addr = count_reg[ADDR_W-1:0];
    assign scan_wr.data = w_masked;

    assign scan_req.start = (state_reg == ST_CHECK) && (lo_reg <= hi_reg);
    assign scan_req.bound = mid_calc;
    assign scan_req.ranks = ranks;
    assign scan_req.count = count_reg;

    mmlbs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept && item.last),
        .dividend (total_next),
        .divisor  (ranks),
        .done     (div_done),
        .quotient (avg)
    );

    mmlbs_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (scan_wr),
        .req   (scan_req),
        .rsp   (scan_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            rank_reg      <= RANK_W'(1);
            count_reg     <= '0;
            total_reg     <= '0;
            largest_reg   <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            res_reg       <= '0;
            mid_reg       <= '0;
            probes_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                rank_reg <= cfg_data;
            end
            case (state_reg)
                ST_LOAD:
                begin
                    if (accept)
                    begin
                        if (room)
                        begin
                            count_reg <= count_reg + 1'b1;
                            total_reg <= total_next;
                            if (w_masked > largest_reg)
                            begin
                                largest_reg <= w_masked;
                            end
                        end
                        if (item.last)
                        begin
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_INIT;
                    end
                end
                ST_INIT:
                begin
                    lo_reg     <= (largest_ext > avg_ext) ? largest_ext : avg_ext;
                    hi_reg     <= avg_ext + largest_ext;
                    res_reg    <= avg_ext + largest_ext;
                    probes_reg <= '0;
                    state_reg  <= ST_CHECK;
                end
                ST_CHECK:
                begin
                    if (lo_reg <= hi_reg)
                    begin
                        mid_reg    <= mid_calc;
                        probes_reg <= probes_reg + 1'b1;
                        state_reg  <= ST_WAIT;
                    end
                    else
                    begin
                        out_valid_reg        <= 1'b1;
                        out_reg.min_max_load <= res_reg[LOAD_W-1:0];
                        out_reg.probe_count  <= probes_reg;
                        count_reg            <= '0;
                        total_reg            <= '0;
                        largest_reg          <= '0;
                        state_reg            <= ST_LOAD;
                    end
                end
                ST_WAIT:
                begin
                    if (scan_rsp.done)
                    begin
                        if (scan_rsp.fit)
                        begin
                            res_reg <= mid_reg;
                            if (mid_reg == lo_reg)
                            begin
                                out_valid_reg        <= 1'b1;
                                out_reg.min_max_load <= mid_reg[LOAD_W-1:0];
                                out_reg.probe_count  <= probes_reg;
                                count_reg            <= '0;
                                total_reg            <= '0;
                                largest_reg          <= '0;
                                state_reg            <= ST_LOAD;
                            end
                            else
                            begin
                                hi_reg    <= mid_reg - 1'b1;
                                state_reg <= ST_CHECK;
                            end
                        end
                        else
                        begin
                            lo_reg    <= mid_reg + 1'b1;
                            state_reg <= ST_CHECK;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    assign busy         = state_reg != ST_LOAD;
    assign cfg_ready    = 1'b1;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule
